FILE: src/pdcd_pkg.sv
// ----------------------------------------------------------------------------
// pdcd_pkg
// shared widths, codes and item types of the source capability decoder
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdcd_pkg;

  // kept table
  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // field widths
  localparam int CAPS_W = 5;
  localparam int WORD_W = 32;
  localparam int VOLT_W = 16;
  localparam int VMIN_W = 15;
  localparam int CUR_W  = 22;
  localparam int BAND_W = 14;
  localparam int PDP_W  = 8;
  localparam int SLOT_OUT_W = 4;

  // epr avs current = pdp * 1e6 / voltage
  localparam int NUM_W = 28;
  localparam logic [NUM_W-1:0] POWER_SCALE = NUM_W'(1000000);
  localparam int DIV_STEP_W = $clog2(NUM_W + 1);

  typedef enum logic [1:0] {
    PDO_FIXED     = 2'd0,
    PDO_BATTERY   = 2'd1,
    PDO_VARIABLE  = 2'd2,
    PDO_AUGMENTED = 2'd3
  } pdo_type_e;

  typedef enum logic [1:0] {
    APDO_PPS     = 2'd0,
    APDO_EPR_AVS = 2'd1,
    APDO_SPR_AVS = 2'd2,
    APDO_RSVD    = 2'd3
  } apdo_type_e;

  // one kept table entry, also the duplicate compare key
  typedef struct packed {
    logic [VOLT_W-1:0] volt;
    logic [VMIN_W-1:0] vmin;
    logic [CUR_W-1:0]  cur;
    logic              pps;
    logic              avs;
  } pdcd_kept_t;

  // decoded item handed from front to back
  typedef struct packed {
    logic              clear;  // list start: drop table
    logic              cand;   // valid object inside the cap limit
    logic              div;    // current still to be derived from power
    logic [PDP_W-1:0]  pdp;
    pdcd_kept_t        kept;
    logic [BAND_W-1:0] band;
  } pdcd_item_t;

  // result handed to the output port
  typedef struct packed {
    pdcd_kept_t            kept;
    logic [BAND_W-1:0]     band;
    logic [SLOT_OUT_W-1:0] slot;
  } pdcd_result_t;

  typedef struct packed {
    logic              start;
    logic [NUM_W-1:0]  num;
    logic [VOLT_W-1:0] den;
  } pdcd_div_req_t;

  typedef struct packed {
    logic             done;
    logic [CUR_W-1:0] quot;
  } pdcd_div_rsp_t;

endpackage

`default_nettype wire

FILE: src/pdcd_front.sv
// ----------------------------------------------------------------------------
// pdcd_front
// accepts objects, applies the list count limit and decodes the object
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdcd_front import pdcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CAPS_W-1:0] cfg_wdata_i,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire logic [WORD_W-1:0] in_word_i,
  input  wire logic              in_start_i,
  input  wire logic              q_full_i,
  output      logic              push_o,
  output      pdcd_item_t        item_o
);

  logic [CAPS_W-1:0] cap_limit_q;
  logic [CAPS_W-1:0] seen_q, seen_d, seen_base;
  logic              in_caps, accept;
  pdo_type_e         ptype;
  apdo_type_e        atype;
  pdcd_item_t        dec;
  logic              cur_ok, range_bad, obj_ok;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign seen_base  = in_start_i ? '0 : seen_q;
  assign in_caps    = seen_base < cap_limit_q;
  assign seen_d     = in_caps ? seen_base + CAPS_W'(1) : seen_base;

  assign ptype = pdo_type_e'(in_word_i[31:30]);
  assign atype = apdo_type_e'(in_word_i[29:28]);

  always_comb begin
    dec       = '0;
    dec.clear = in_start_i;
    case (ptype)
      PDO_AUGMENTED: begin
        case (atype)
          APDO_PPS: begin
            dec.kept.pps  = 1'b1;
            dec.kept.volt = VOLT_W'(in_word_i[24:17]) * VOLT_W'(100);
            dec.kept.vmin = VMIN_W'(in_word_i[15:8]) * VMIN_W'(100);
            dec.kept.cur  = CUR_W'(in_word_i[6:0]) * CUR_W'(50);
          end
          APDO_EPR_AVS: begin
            dec.kept.avs  = 1'b1;
            dec.div       = 1'b1;
            dec.pdp       = in_word_i[7:0];
            dec.kept.volt = VOLT_W'(in_word_i[25:17]) * VOLT_W'(100);
            dec.kept.vmin = VMIN_W'(in_word_i[15:8]) * VMIN_W'(100);
          end
          APDO_SPR_AVS: begin
            dec.kept.avs  = 1'b1;
            dec.kept.vmin = VMIN_W'(9000);
            dec.band      = BAND_W'(in_word_i[19:10]) * BAND_W'(10);
            if (in_word_i[9:0] != '0) begin
              dec.kept.volt = VOLT_W'(20000);
              dec.kept.cur  = CUR_W'(in_word_i[9:0]) * CUR_W'(10);
            end else begin
              dec.kept.volt = VOLT_W'(15000);
              dec.kept.cur  = CUR_W'(dec.band);
            end
          end
          default: begin
            // reserved subtype decodes to all zero and is dropped
          end
        endcase
      end
      default: begin
        dec.kept.volt = VOLT_W'(in_word_i[19:10]) * VOLT_W'(50);
        dec.kept.cur  = CUR_W'(in_word_i[9:0]) * CUR_W'(10);
      end
    endcase

    // power-derived current is zero only for zero power
    cur_ok    = dec.div ? (dec.pdp != '0) : (dec.kept.cur != '0);
    range_bad = (dec.kept.pps || dec.kept.avs) &&
                (VOLT_W'(dec.kept.vmin) >= dec.kept.volt);
    obj_ok    = (dec.kept.volt != '0) && cur_ok && !range_bad;
    dec.cand  = in_caps && obj_ok;
  end

  assign item_o = dec;
  assign push_o = accept && (dec.clear || dec.cand);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_limit_q <= CAPS_W'(16);
      seen_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        cap_limit_q <= cfg_wdata_i;
      end
      if (accept) begin
        seen_q <= seen_d;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/pdcd_queue.sv
// ----------------------------------------------------------------------------
// pdcd_queue
// short fifo of decoded items between front and back
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdcd_queue import pdcd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  wire pdcd_item_t push_data_i,
  output      logic       full_o,
  input  wire logic       pop_i,
  output      pdcd_item_t pop_data_o,
  output      logic       empty_o
);

  pdcd_item_t        mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              do_push, do_pop;

  function automatic logic [QPTR_W-1:0] ptr_next(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full_o     = cnt_q == QCNT_W'(QUEUE_DEPTH);
  assign empty_o    = cnt_q == '0;
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/pdcd_div.sv
// ----------------------------------------------------------------------------
// pdcd_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdcd_div import pdcd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire pdcd_div_req_t req_i,
  output      pdcd_div_rsp_t rsp_o
);

  logic                  busy_q, done_q;
  logic [DIV_STEP_W-1:0] step_q;
  logic [VOLT_W-1:0]     rem_q, den_q;
  logic [NUM_W-1:0]      acc_q;   // dividend shifts out, quotient shifts in
  logic [VOLT_W:0]       trial;
  logic                  ge;

  assign trial = {rem_q, acc_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  assign rsp_o.done = done_q;
  assign rsp_o.quot = acc_q[CUR_W-1:0];

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= '0;
      acc_q <= req_i.num;
      den_q <= req_i.den;
    end else if (busy_q) begin
      rem_q <= ge ? VOLT_W'(trial - {1'b0, den_q}) : VOLT_W'(trial);
      acc_q <= {acc_q[NUM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= DIV_STEP_W'(NUM_W);
      end else if (busy_q) begin
        step_q <= step_q - DIV_STEP_W'(1);
        if (step_q == DIV_STEP_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/pdcd_back.sv
// ----------------------------------------------------------------------------
// pdcd_back
// derives epr avs current, scans the kept table for duplicates, keeps and
// emits new entries
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdcd_back import pdcd_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         q_empty_i,
  input  wire pdcd_item_t   q_data_i,
  output      logic         q_pop_o,
  output      logic         out_valid_o,
  input  wire logic         out_ready_i,
  output      pdcd_result_t out_data_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_CHECK,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e        state_q;
  pdcd_item_t    ent_q;
  logic [CNT_W-1:0] kept_q, idx_q;
  logic          pend_q;
  logic          out_valid_q;
  pdcd_result_t  out_q;

  pdcd_kept_t    table_q [MAX_ENTRIES];
  pdcd_kept_t    rd_data_q;

  pdcd_div_req_t div_req;
  pdcd_div_rsp_t div_rsp;
  logic          pop, rd_en, emit, match;

  assign pop   = (state_q == ST_IDLE) && !q_empty_i;
  assign rd_en = (state_q == ST_SCAN) && (idx_q < kept_q);
  assign emit  = (state_q == ST_EMIT) && (!out_valid_q || out_ready_i);
  assign match = rd_data_q == ent_q.kept;

  assign div_req.start = pop && q_data_i.cand && q_data_i.div;
  assign div_req.num   = NUM_W'(q_data_i.pdp) * POWER_SCALE;
  assign div_req.den   = q_data_i.kept.volt;

  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  pdcd_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // kept table
  always_ff @(posedge clk_i) begin
    if (emit) begin
      table_q[kept_q[SLOT_W-1:0]] <= ent_q.kept;
    end
    if (rd_en) begin
      rd_data_q <= table_q[idx_q[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ent_q       <= '0;
      kept_q      <= '0;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (pop) begin
            ent_q <= q_data_i;
            if (q_data_i.clear) begin
              kept_q <= '0;
            end
            if (q_data_i.cand) begin
              state_q <= q_data_i.div ? ST_DIV : ST_CHECK;
            end
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            ent_q.kept.cur <= div_rsp.quot;
            state_q        <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          idx_q  <= '0;
          pend_q <= 1'b0;
          // table full: new entries are dropped
          state_q <= (kept_q >= CNT_W'(MAX_ENTRIES)) ? ST_IDLE : ST_SCAN;
        end
        ST_SCAN: begin
          pend_q <= rd_en;
          if (rd_en) begin
            idx_q <= idx_q + CNT_W'(1);
          end
          if (pend_q && match) begin
            state_q <= ST_IDLE;
          end else if (!rd_en && !pend_q) begin
            state_q <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (emit) begin
            out_valid_q <= 1'b1;
            out_q.kept  <= ent_q.kept;
            out_q.band  <= ent_q.band;
            out_q.slot  <= SLOT_OUT_W'(kept_q);
            kept_q      <= kept_q + CNT_W'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: src/pd_source_caps_decoder.sv
// ----------------------------------------------------------------------------
// pd_source_caps_decoder
// usb pd source capability decoder, one power data object per transfer
// ----------------------------------------------------------------------------
// Each input transfer carries one 32-bit power data object in s_axis_tdata;
// s_axis_tuser high marks the first object of a capability list and clears
// the kept table and the counters. Objects beyond the cap limit of a list are
// ignored; invalid objects (zero voltage or current, or a programmable range
// whose minimum is not below its maximum) and duplicates of a kept entry give
// no output. Every newly kept entry leaves as one output transfer with its
// slot index. The front decodes and accepts one object per cycle into a
// two-entry queue while it has room; the back then works on one item at a
// time: for EPR AVS objects a bit-serial divide first derives current from
// power; then a duplicate scan goes through the registered table read port
// over every entry already kept in the list, and a new entry is kept and
// emitted, waiting on any output stall. A list start with no valid object
// only clears the kept table in the back; ignored and invalid objects never
// reach it. The user must write the cap limit through cfg_we_i/cfg_wdata_i
// only while no object is in flight; the block does not enforce this. It
// resets to 16.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pd_source_caps_decoder import pdcd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // configuration: cap limit
  input  wire logic              cfg_we_i,
  input  wire logic [CAPS_W-1:0] cfg_wdata_i,
  // object input
  input  wire logic              s_axis_tvalid,
  output      logic              s_axis_tready,
  input  wire logic [31:0]       s_axis_tdata,   // [31:0] pdo_word
  input  wire logic [0:0]        s_axis_tuser,   // [0] list_start
  // kept entry output
  output      logic              m_axis_tvalid,
  input  wire logic              m_axis_tready,
  // [15:0] voltage, [30:16] min voltage, [52:31] current,
  // [66:53] band_low_current_ma, [70:67] slot_index, [71] zero
  output      logic [71:0]       m_axis_tdata,
  output      logic [1:0]        m_axis_tuser    // [0] is_pps, [1] is_avs
);

  pdcd_item_t   push_item, pop_item;
  logic         push, q_full, q_empty, q_pop;
  pdcd_result_t res;

  // accept, count and decode
  pdcd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_word_i   (s_axis_tdata),
    .in_start_i  (s_axis_tuser[0]),
    .q_full_i    (q_full),
    .push_o      (push),
    .item_o      (push_item)
  );

  // decoded items wait here while the back is busy
  pdcd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .pop_data_o  (pop_item),
    .empty_o     (q_empty)
  );

  // divide, duplicate scan, keep and emit
  pdcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_data_i    (pop_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = {1'b0, res.slot, res.band, res.kept.cur,
                         res.kept.vmin, res.kept.volt};
  assign m_axis_tuser = {res.kept.avs, res.kept.pps};

endmodule

`default_nettype wire
